// ===== rtl/rgdd_pkg.sv =====
`default_nettype none

package rgdd_pkg;

  localparam int unsigned FIELD_BITS = 64;
  localparam int unsigned NUM_PHASES = 12;

  // group flag bit positions
  localparam int unsigned FB_INFO   = 0;
  localparam int unsigned FB_ODELTA = 1;
  localparam int unsigned FB_BYADD  = 2;
  localparam int unsigned FB_HASADD = 3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_WRONG    = 2'd1;
  localparam logic [1:0] ST_FINISHED = 2'd2;

  localparam logic MODE_WORD = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef enum logic [3:0] {
    P_TOTAL   = 4'd0,
    P_START   = 4'd1,
    P_GSIZE   = 4'd2,
    P_GFLAGS  = 4'd3,
    P_GDELTA  = 4'd4,
    P_GINFO   = 4'd5,
    P_GADDEND = 4'd6,
    P_EOFF    = 4'd7,
    P_EINFO   = 4'd8,
    P_EADD    = 4'd9,
    P_TICK    = 4'd10,
    P_DONE    = 4'd11
  } phase_e;

  typedef struct packed {
    logic                  mode;
    logic [FIELD_BITS-1:0] word;
  } req_t;

  typedef struct packed {
    logic                  rec_valid;
    logic [FIELD_BITS-1:0] rec_offset;
    logic [FIELD_BITS-1:0] rec_info;
    logic [FIELD_BITS-1:0] rec_addend;
    logic                  rec_last;
    logic                  need_word;
    logic [1:0]            status;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/rgdd_req_if.sv =====
`default_nettype none

interface rgdd_req_if;
  import rgdd_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/rgdd_res_if.sv =====
`default_nettype none

interface rgdd_res_if;
  import rgdd_pkg::*;

  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/rgdd_core.sv =====
`default_nettype none

module rgdd_core #(
  parameter int unsigned WORD_BITS = 64
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          step_i,
  input  rgdd_pkg::req_t     req_i,
  output rgdd_pkg::res_t     res_o
);
  import rgdd_pkg::*;

  localparam int unsigned W = WORD_BITS;

  typedef struct packed {
    logic   found;
    phase_e ph;
  } hit_t;

  function automatic logic needed(phase_e p, logic [3:0] f);
    logic add_shared;
    logic add_each;
    add_shared = f[FB_HASADD] & f[FB_BYADD];
    add_each   = f[FB_HASADD] & ~f[FB_BYADD];
    case (p)
      P_GDELTA:  return f[FB_ODELTA];
      P_GINFO:   return f[FB_INFO];
      P_GADDEND: return add_shared;
      P_EOFF:    return ~f[FB_ODELTA];
      P_EINFO:   return ~f[FB_INFO];
      P_EADD:    return add_each;
      P_TICK:    return f[FB_ODELTA] & f[FB_INFO] & ~add_each;
      default:   return 1'b0;
    endcase
  endfunction

  // first phase above lo and up to hi that the flags call for
  function automatic hit_t find_after(phase_e lo, phase_e hi, logic [3:0] f);
    hit_t       h;
    logic [3:0] q;
    h.found = 1'b0;
    h.ph    = P_TOTAL;
    for (int i = 0; i < NUM_PHASES; i++) begin
      q = 4'(i);
      if (!h.found && (q > lo) && (q <= hi) && needed(phase_e'(q), f)) begin
        h.found = 1'b1;
        h.ph    = phase_e'(q);
      end
    end
    return h;
  endfunction

  phase_e       phase_q, phase_d;
  logic [W-1:0] total_q, total_d;
  logic [W-1:0] done_q, done_d;
  logic [W-1:0] left_q, left_d;
  logic [3:0]   flags_q, flags_d;
  logic [W-1:0] shared_q, shared_d;
  logic [W-1:0] off_q, off_d;
  logic [W-1:0] info_q, info_d;
  logic [W-1:0] add_q, add_d;

  logic [W-1:0] w;
  logic [3:0]   flags_new;
  logic         hdr;
  logic         elem;
  hit_t         hit_hdr;
  hit_t         hit_elem;
  hit_t         first_new;
  hit_t         first_old;
  res_t         res;

  assign w = req_i.word[W-1:0];

  // flags that hold once the current request is taken
  assign flags_new = (phase_q == P_GFLAGS) ? w[3:0] : flags_q;

  assign hit_hdr   = find_after(phase_q, P_GADDEND, flags_new);
  assign first_new = find_after(P_GADDEND, P_TICK, flags_new);
  assign hit_elem  = find_after(phase_q, P_TICK, flags_q);
  assign first_old = find_after(P_GADDEND, P_TICK, flags_q);

  always_comb begin
    phase_d  = phase_q;
    total_d  = total_q;
    done_d   = done_q;
    left_d   = left_q;
    flags_d  = flags_q;
    shared_d = shared_q;
    off_d    = off_q;
    info_d   = info_q;
    add_d    = add_q;
    hdr      = 1'b0;
    elem     = 1'b0;
    res      = '0;

    if (phase_q >= P_DONE) begin
      res.status = ST_FINISHED;
    end else if (req_i.mode != ((phase_q == P_TICK) ? MODE_TICK : MODE_WORD)) begin
      res.status = ST_WRONG;
    end else begin
      res.status = ST_OK;
      case (phase_q)
        P_TOTAL: begin
          total_d = w;
          phase_d = P_START;
        end
        P_START: begin
          off_d   = w;
          phase_d = (done_q >= total_q) ? P_DONE : P_GSIZE;
        end
        P_GSIZE: begin
          left_d  = w;
          phase_d = P_GFLAGS;
        end
        P_GFLAGS: begin
          flags_d = w[3:0];
          hdr     = 1'b1;
        end
        P_GDELTA: begin
          shared_d = w;
          hdr      = 1'b1;
        end
        P_GINFO: begin
          info_d = w;
          hdr    = 1'b1;
        end
        P_GADDEND: begin
          add_d = add_q + w;
          hdr   = 1'b1;
        end
        P_EOFF: begin
          off_d = off_q + w;
          elem  = 1'b1;
        end
        P_EINFO: begin
          info_d = w;
          elem   = 1'b1;
        end
        P_EADD: begin
          add_d = add_q + w;
          elem  = 1'b1;
        end
        P_TICK: begin
          elem = 1'b1;
        end
        default: begin
        end
      endcase

      if (hdr) begin
        if (hit_hdr.found) begin
          phase_d = hit_hdr.ph;
        end else if (left_q == '0) begin
          phase_d = (done_q >= total_q) ? P_DONE : P_GSIZE;
        end else begin
          phase_d = first_new.ph;
        end
      end

      if (elem) begin
        if (hit_elem.found) begin
          phase_d = hit_elem.ph;
        end else begin
          // shared offset delta never comes with a per-element offset word
          if (flags_q[FB_ODELTA]) begin
            off_d = off_q + shared_q;
          end
          left_d = left_q - W'(1);
          done_d = done_q + W'(1);
          res.rec_valid  = 1'b1;
          res.rec_offset = FIELD_BITS'(off_d);
          res.rec_info   = FIELD_BITS'(info_d);
          res.rec_addend = FIELD_BITS'(add_d);
          if (left_d == '0) begin
            if (done_d >= total_q) begin
              phase_d      = P_DONE;
              res.rec_last = 1'b1;
            end else begin
              phase_d = P_GSIZE;
            end
          end else begin
            phase_d = first_old.ph;
          end
        end
      end
    end

    res.need_word = (phase_d != P_TICK);
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= P_TOTAL;
      total_q  <= '0;
      done_q   <= '0;
      left_q   <= '0;
      flags_q  <= '0;
      shared_q <= '0;
      off_q    <= '0;
      info_q   <= '0;
      add_q    <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      total_q  <= total_d;
      done_q   <= done_d;
      left_q   <= left_d;
      flags_q  <= flags_d;
      shared_q <= shared_d;
      off_q    <= off_d;
      info_q   <= info_d;
      add_q    <= add_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/relocation_group_delta_decoder_unit.sv =====
// Packed relocation stream decoder. Each request is either a stream word
// (mode 0) or a tick (mode 1) that advances an element carrying no word; every
// request yields exactly one result, whose need_word bit tells the feeder what
// kind of request must come next. Requests pass through an input register and
// the decode plus the update of the running offset, info and addend happen
// combinationally into a result register, so one request is taken per clock
// cycle while the result register is empty or being read. The rate is set by
// the single decode stage, whose state registers are rewritten each time a
// request advances.
// Running values are WORD_BITS wide and are zero-extended on the result port.
`default_nettype none

module relocation_group_delta_decoder_unit #(
  parameter int unsigned WORD_BITS = 64
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  rgdd_req_if.sink   req,
  rgdd_res_if.source res
);
  import rgdd_pkg::*;

  logic in_vld_q;
  req_t in_q;
  logic out_vld_q;
  res_t out_q;
  res_t res_next;
  logic adv;

  assign adv       = in_vld_q & (~out_vld_q | res.ready);
  assign req.ready = ~in_vld_q | adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (req.valid && req.ready) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) begin
      in_q <= req.data;
    end
  end

  rgdd_core #(
    .WORD_BITS(WORD_BITS)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(adv),
    .req_i (in_q),
    .res_o (res_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (res.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res_next;
    end
  end

  assign res.valid = out_vld_q;
  assign res.data  = out_q;

endmodule

`default_nettype wire

// ===== rtl/rgdd_checker.sv =====
`default_nettype none

module rgdd_checker (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     res_valid_i,
  input wire logic     res_ready_i,
  input rgdd_pkg::res_t res_data_i
);
  import rgdd_pkg::*;

  // ignored requests carry no record
  a_ignored_no_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_data_i.status != ST_OK) |-> !res_data_i.rec_valid)
    else $error("record on an ignored request");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (res_data_i.status == ST_OK) || (res_data_i.status == ST_WRONG) ||
                    (res_data_i.status == ST_FINISHED))
    else $error("undefined status code");

  a_no_rec_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_data_i.rec_valid |->
      (res_data_i.rec_offset == '0) && (res_data_i.rec_info == '0) &&
      (res_data_i.rec_addend == '0) && !res_data_i.rec_last)
    else $error("record fields set without a record");

  // last record finishes the stream, which then asks for words only
  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_ready_i && res_data_i.rec_last |->
      res_data_i.rec_valid && res_data_i.need_word)
    else $error("bad last record");

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_data_i))
    else $error("stalled result changed");

endmodule

bind relocation_group_delta_decoder_unit rgdd_checker u_rgdd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .res_valid_i(res.valid),
  .res_ready_i(res.ready),
  .res_data_i (res.data)
);

`default_nettype wire
